>>> hw/rtl/bmhpq_pkg.sv
// shared constants, codes and controller/datapath interface types for the heap queue
package bmhpq_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int VAL_W = 32;
    localparam int CMD_W = 2;
    localparam int POS_W = 6;
    localparam int STS_W = 2;
    localparam int CNT_OUT_W = 7;

    localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EXTRACT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CHANGE  = 2'd3;

    localparam logic [STS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STS_W-1:0] ST_BADPOS = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic             accept;
        logic [STS_W-1:0] status;
        logic             take_top;
        logic             ins_init;
        logic             rd_pos;
        logic             load_old;
        logic             dec_last;
        logic             load_last;
        logic             rd_parent;
        logic             up_move;
        logic             rd_kids;
        logic             down_move;
        logic             place;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic bad_pos;
        logic one_left;
        logic at_root;
        logic up_gt;
        logic no_left;
        logic child_gt;
    } t_dp_sts;

endpackage

>>> hw/rtl/binary_max_heap_priority_queue.sv
// binary max-heap priority queue: top level joining controller and datapath
// one command beat is taken when start is high and busy is low; one result beat follows
// errors report in the next cycle; every compare waits on the registered slot read;
// remove lifts the entry to the root, drops it, refills from the last slot, sifts down;
// busy drops in the result cycle, so a new command may enter there
// o_valid marks each result for one cycle only; the receiver cannot stall it
// synchronous active-low reset empties the queue; slot contents stay undefined until written
module binary_max_heap_priority_queue #(
    parameter int CAPACITY = bmhpq_pkg::CAPACITY_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    input  logic [bmhpq_pkg::CMD_W-1:0]          i_command,
    input  logic signed [bmhpq_pkg::VAL_W-1:0]   i_new_value,
    input  logic [bmhpq_pkg::POS_W-1:0]          i_position,
    output logic                                 busy,
    output logic                                 o_valid,
    output logic [bmhpq_pkg::STS_W-1:0]          o_status,
    output logic signed [bmhpq_pkg::VAL_W-1:0]   o_taken_value,
    output logic signed [bmhpq_pkg::VAL_W-1:0]   o_top_value,
    output logic [bmhpq_pkg::CNT_OUT_W-1:0]      o_entry_count
);
    import bmhpq_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    bmhpq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_command),
        .i_sts     (dp_sts),
        .o_cmd     (dp_cmd),
        .busy      (busy),
        .o_valid   (o_valid)
    );

    bmhpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_new_value   (i_new_value),
        .i_position    (i_position),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .o_status      (o_status),
        .o_taken_value (o_taken_value),
        .o_top_value   (o_top_value),
        .o_entry_count (o_entry_count)
    );

endmodule

>>> hw/rtl/bmhpq_dp.sv
// heap datapath: slot memory, moving entry, index arithmetic, compares and result registers
module bmhpq_dp #(
    parameter int CAPACITY = bmhpq_pkg::CAPACITY_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic signed [bmhpq_pkg::VAL_W-1:0]   i_new_value,
    input  logic [bmhpq_pkg::POS_W-1:0]          i_position,
    input  bmhpq_pkg::t_dp_cmd                   i_cmd,
    output bmhpq_pkg::t_dp_sts                   o_sts,
    output logic [bmhpq_pkg::STS_W-1:0]          o_status,
    output logic signed [bmhpq_pkg::VAL_W-1:0]   o_taken_value,
    output logic signed [bmhpq_pkg::VAL_W-1:0]   o_top_value,
    output logic [bmhpq_pkg::CNT_OUT_W-1:0]      o_entry_count
);
    import bmhpq_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = IW + 2;

    logic [VAL_W-1:0]        r_mem [CAPACITY];
    logic signed [VAL_W-1:0] r_rd_a;
    logic signed [VAL_W-1:0] r_rd_b;
    logic signed [VAL_W-1:0] r_cur;
    logic signed [VAL_W-1:0] r_top;
    logic signed [VAL_W-1:0] r_taken;
    logic [STS_W-1:0]        r_status;
    logic [POS_W-1:0]        r_pos;
    logic [IW-1:0]           r_idx;
    logic [CW-1:0]           r_cnt;

    logic [IW-1:0]           parent;
    logic [KW-1:0]           left_k;
    logic [KW-1:0]           right_k;
    logic [KW-1:0]           cnt_k;
    logic [KW-1:0]           idx_k;
    logic [KW-1:0]           child_k;
    logic                    right_ok;
    logic                    take_right;
    logic signed [VAL_W-1:0] sel;
    logic [CW-1:0]           cnt_m1;
    logic [IW+POS_W-1:0]     ipos_ext;
    logic [IW+POS_W-1:0]     rpos_ext;
    logic [CW+POS_W-1:0]     pos_cmp;
    logic [CW+POS_W-1:0]     cnt_cmp;
    logic [CW+CNT_OUT_W-1:0] cnt_out;

    logic                    wr_en;
    logic [IW-1:0]           wr_addr;
    logic [VAL_W-1:0]        wr_data;
    logic                    rd_en;
    logic [IW-1:0]           rd_addr_a;

    assign parent   = (r_idx - IW'(1)) >> 1;
    assign idx_k    = {2'b00, r_idx};
    assign left_k   = {1'b0, r_idx, 1'b1};
    assign right_k  = left_k + KW'(1);
    assign cnt_k    = {{(KW-CW){1'b0}}, r_cnt};
    assign right_ok = right_k < cnt_k;
    assign cnt_m1   = r_cnt - CW'(1);
    assign ipos_ext = {{IW{1'b0}}, i_position};
    assign rpos_ext = {{IW{1'b0}}, r_pos};
    assign pos_cmp  = {{CW{1'b0}}, i_position};
    assign cnt_cmp  = {{POS_W{1'b0}}, r_cnt};

    // larger child, left wins a tie
    assign take_right = right_ok && (r_rd_b > r_rd_a);
    assign sel        = take_right ? r_rd_b : r_rd_a;
    assign child_k    = take_right ? right_k : left_k;

    assign o_sts.full     = r_cnt == CW'(CAPACITY);
    assign o_sts.empty    = r_cnt == CW'(0);
    assign o_sts.bad_pos  = pos_cmp >= cnt_cmp;
    assign o_sts.one_left = r_cnt == CW'(1);
    assign o_sts.at_root  = r_idx == IW'(0);
    assign o_sts.up_gt    = r_cur > r_rd_a;
    assign o_sts.no_left  = left_k >= cnt_k;
    assign o_sts.child_gt = sel > r_cur;

    // write port: the moving entry lands, or a neighbor shifts into the hole
    always_comb begin
        wr_en   = i_cmd.place | i_cmd.up_move | i_cmd.down_move;
        wr_addr = r_idx;
        wr_data = r_cur;
        if (i_cmd.up_move) begin
            wr_data = r_rd_a;
        end else if (i_cmd.down_move) begin
            wr_data = sel;
        end
    end

    always_comb begin
        rd_en     = i_cmd.rd_pos | i_cmd.rd_parent | i_cmd.dec_last | i_cmd.rd_kids;
        rd_addr_a = left_k[IW-1:0];
        if (i_cmd.rd_pos) begin
            rd_addr_a = ipos_ext[IW-1:0];
        end else if (i_cmd.rd_parent) begin
            rd_addr_a = parent;
        end else if (i_cmd.dec_last) begin
            rd_addr_a = cnt_m1[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_a <= r_mem[rd_addr_a];
            r_rd_b <= r_mem[right_k[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.ins_init) begin
            r_cnt <= r_cnt + CW'(1);
        end else if (i_cmd.dec_last) begin
            r_cnt <= cnt_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && wr_addr == IW'(0)) begin
            r_top <= wr_data;
        end
        if (i_cmd.accept) begin
            r_cur    <= i_new_value;
            r_pos    <= i_position;
            r_status <= i_cmd.status;
        end else if (i_cmd.load_last) begin
            r_cur <= r_rd_a;
        end
        if (i_cmd.take_top) begin
            r_taken <= r_top;
        end else if (i_cmd.accept) begin
            r_taken <= '0;
        end else if (i_cmd.load_old) begin
            r_taken <= r_rd_a;
        end
        if (i_cmd.ins_init) begin
            r_idx <= r_cnt[IW-1:0];
        end else if (i_cmd.load_old) begin
            r_idx <= rpos_ext[IW-1:0];
        end else if (i_cmd.load_last) begin
            r_idx <= IW'(0);
        end else if (i_cmd.up_move) begin
            r_idx <= parent;
        end else if (i_cmd.down_move) begin
            r_idx <= child_k[IW-1:0];
        end
    end

    assign cnt_out       = {{CNT_OUT_W{1'b0}}, r_cnt};
    assign o_entry_count = cnt_out[CNT_OUT_W-1:0];
    assign o_status      = r_status;
    assign o_taken_value = r_taken;
    assign o_top_value   = (r_cnt != CW'(0)) ? r_top : '0;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_wr_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> idx_k < cnt_k)
        else $error("slot write outside the live heap");

    a_child_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.down_move |-> child_k < cnt_k)
        else $error("sift-down moved to a missing child");
`endif

endmodule

>>> hw/rtl/bmhpq_ctrl.sv
// heap controller: command decode and sift sequencing state machine
module bmhpq_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic [bmhpq_pkg::CMD_W-1:0]   i_command,
    input  bmhpq_pkg::t_dp_sts            i_sts,
    output bmhpq_pkg::t_dp_cmd            o_cmd,
    output logic                          busy,
    output logic                          o_valid
);
    import bmhpq_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_OLD     = 4'd1;
    localparam logic [3:0] S_UP_RD   = 4'd2;
    localparam logic [3:0] S_UP_CMP  = 4'd3;
    localparam logic [3:0] S_LIFT_RD = 4'd4;
    localparam logic [3:0] S_LIFT_WR = 4'd5;
    localparam logic [3:0] S_LAST    = 4'd6;
    localparam logic [3:0] S_DN_RD   = 4'd7;
    localparam logic [3:0] S_DN_CMP  = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    logic [3:0]       r_state;
    logic [3:0]       n_state;
    logic [CMD_W-1:0] r_cmd;
    logic [CMD_W-1:0] n_cmd;
    logic             ready;
    t_dp_cmd          dc;

    assign ready = (r_state == S_IDLE) || (r_state == S_DONE);

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        dc      = '0;
        case (r_state)
            S_IDLE, S_DONE: begin
                n_state = S_IDLE;
                if (start) begin
                    dc.accept = 1'b1;
                    dc.status = ST_OK;
                    n_cmd     = i_command;
                    if (i_command == CMD_INSERT) begin
                        if (i_sts.full) begin
                            dc.status = ST_FULL;
                            n_state   = S_DONE;
                        end else begin
                            dc.ins_init = 1'b1;
                            n_state     = S_UP_RD;
                        end
                    end else if (i_sts.empty) begin
                        dc.status = ST_EMPTY;
                        n_state   = S_DONE;
                    end else if (i_command == CMD_EXTRACT) begin
                        dc.take_top = 1'b1;
                        dc.dec_last = 1'b1;
                        n_state     = i_sts.one_left ? S_DONE : S_LAST;
                    end else if (i_sts.bad_pos) begin
                        dc.status = ST_BADPOS;
                        n_state   = S_DONE;
                    end else begin
                        dc.rd_pos = 1'b1;
                        n_state   = S_OLD;
                    end
                end
            end
            S_OLD: begin
                dc.load_old = 1'b1;
                if (r_cmd == CMD_REMOVE) begin
                    n_state = S_LIFT_RD;
                end else if (i_sts.up_gt) begin
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_DN_RD;
                end
            end
            S_UP_RD: begin
                if (i_sts.at_root) begin
                    dc.place = 1'b1;
                    n_state  = S_DONE;
                end else begin
                    dc.rd_parent = 1'b1;
                    n_state      = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_sts.up_gt) begin
                    dc.up_move = 1'b1;
                    n_state    = S_UP_RD;
                end else begin
                    dc.place = 1'b1;
                    n_state  = S_DONE;
                end
            end
            S_LIFT_RD: begin
                // entry reached the root: drop it and refill from the last slot
                if (i_sts.at_root) begin
                    dc.dec_last = 1'b1;
                    n_state     = i_sts.one_left ? S_DONE : S_LAST;
                end else begin
                    dc.rd_parent = 1'b1;
                    n_state      = S_LIFT_WR;
                end
            end
            S_LIFT_WR: begin
                dc.up_move = 1'b1;
                n_state    = S_LIFT_RD;
            end
            S_LAST: begin
                dc.load_last = 1'b1;
                n_state      = S_DN_RD;
            end
            S_DN_RD: begin
                if (i_sts.no_left) begin
                    dc.place = 1'b1;
                    n_state  = S_DONE;
                end else begin
                    dc.rd_kids = 1'b1;
                    n_state    = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                if (i_sts.child_gt) begin
                    dc.down_move = 1'b1;
                    n_state      = S_DN_RD;
                end else begin
                    dc.place = 1'b1;
                    n_state  = S_DONE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd   <= CMD_INSERT;
        end else begin
            r_state <= n_state;
            r_cmd   <= n_cmd;
        end
    end

    assign o_cmd   = dc;
    assign busy    = !ready;
    assign o_valid = r_state == S_DONE;

`ifndef SYNTHESIS
    a_no_write_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ready |-> !(dc.place || dc.up_move || dc.down_move))
        else $error("slot write while waiting for a command");

    a_error_beat_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && ready && dc.status != ST_OK) |=> o_valid)
        else $error("rejected command did not report in the next cycle");
`endif

endmodule
